### rtl/sfk_pkg.sv
// Shared types, constants and tables for the six-joint forward kinematics block.
package sfk_pkg;

  localparam int ANGLE_WIDTH  = 16;
  localparam int COORD_WIDTH  = 32;
  localparam int CFG_WIDTH    = 20;
  localparam int ROT_WIDTH    = 16;
  localparam int POS_WIDTH    = 20;
  localparam int TRIG_W       = 32;
  localparam int CORDIC_W     = 33;
  localparam int PROD_W       = 64;
  localparam int JOINTS       = 6;
  localparam int LINKS        = 8;
  localparam int CORDIC_STEPS = 20;
  localparam int OFS_W        = 17;

  localparam logic signed [31:0]       PHASE_MUL = 32'sd83443;
  localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 33'sd652032874;
  localparam logic signed [TRIG_W-1:0] Q30_ONE   = 32'sd1073741824;
  localparam logic signed [CFG_WIDTH-1:0] BASE_HEIGHT_RST = 20'sd131072;
  localparam int ROT_LIMIT = 16384;
  localparam int POS_LIMIT = 327680;

  typedef logic signed [TRIG_W-1:0] trig_val_t;

  typedef struct packed {
    trig_val_t [JOINTS-1:0] cosv;
    trig_val_t [JOINTS-1:0] sinv;
  } trig_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {AX_NONE, AX_Z, AX_Y} axis_t;

  typedef struct packed {
    axis_t                   axis;
    logic [2:0]              joint;
    logic [1:0]              t_axis;
    logic signed [OFS_W-1:0] t_val;
  } link_t;

  typedef enum logic [1:0] {F_IDLE, F_RUN, F_PUSH} f_state_t;
  typedef enum logic [1:0] {B_IDLE, B_RUN, B_DONE} b_state_t;

  // arctangent table, 2^32 per turn
  function automatic logic signed [CORDIC_W-1:0] atan_val(input logic [4:0] i);
    logic signed [CORDIC_W-1:0] v;
    case (i)
      5'd0:  v = 33'sd536870912;
      5'd1:  v = 33'sd316933406;
      5'd2:  v = 33'sd167458907;
      5'd3:  v = 33'sd85004756;
      5'd4:  v = 33'sd42667331;
      5'd5:  v = 33'sd21354465;
      5'd6:  v = 33'sd10679838;
      5'd7:  v = 33'sd5340245;
      5'd8:  v = 33'sd2670163;
      5'd9:  v = 33'sd1335087;
      5'd10: v = 33'sd667544;
      5'd11: v = 33'sd333772;
      5'd12: v = 33'sd166886;
      5'd13: v = 33'sd83443;
      5'd14: v = 33'sd41722;
      5'd15: v = 33'sd20861;
      5'd16: v = 33'sd10430;
      5'd17: v = 33'sd5215;
      5'd18: v = 33'sd2608;
      5'd19: v = 33'sd1304;
      default: v = '0;
    endcase
    return v;
  endfunction

  // link chain: rotation axis, joint, offset axis and offset in Q16
  function automatic link_t link_info(input logic [2:0] k);
    link_t l;
    case (k)
      3'd0: l = '{AX_Z,    3'd0, 2'd2, 17'sd8343};
      3'd1: l = '{AX_Y,    3'd1, 2'd1, 17'sd14480};
      3'd2: l = '{AX_Y,    3'd2, 2'd0, 17'sd40108};
      3'd3: l = '{AX_NONE, 3'd0, 2'd1, -17'sd11266};
      3'd4: l = '{AX_Y,    3'd3, 2'd0, 17'sd37506};
      3'd5: l = '{AX_Z,    3'd4, 2'd1, 17'sd7530};
      3'd6: l = '{AX_Y,    3'd5, 2'd2, -17'sd7583};
      default: l = '{AX_NONE, 3'd0, 2'd1, 17'sd11246};
    endcase
    return l;
  endfunction

endpackage

### rtl/sfk_if.sv
// Valid/ready channel interfaces for joint angles and tool pose.
interface sfk_in_if import sfk_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [ANGLE_WIDTH-1:0] joint1_angle;
  logic signed [ANGLE_WIDTH-1:0] joint2_angle;
  logic signed [ANGLE_WIDTH-1:0] joint3_angle;
  logic signed [ANGLE_WIDTH-1:0] joint4_angle;
  logic signed [ANGLE_WIDTH-1:0] joint5_angle;
  logic signed [ANGLE_WIDTH-1:0] joint6_angle;

  modport source (output valid, joint1_angle, joint2_angle, joint3_angle,
                  joint4_angle, joint5_angle, joint6_angle, input ready);
  modport sink (input valid, joint1_angle, joint2_angle, joint3_angle,
                joint4_angle, joint5_angle, joint6_angle, output ready);
endinterface

interface sfk_out_if import sfk_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [ROT_WIDTH-1:0] rot_r0c0;
  logic signed [ROT_WIDTH-1:0] rot_r0c1;
  logic signed [ROT_WIDTH-1:0] rot_r0c2;
  logic signed [ROT_WIDTH-1:0] rot_r1c0;
  logic signed [ROT_WIDTH-1:0] rot_r1c1;
  logic signed [ROT_WIDTH-1:0] rot_r1c2;
  logic signed [ROT_WIDTH-1:0] rot_r2c0;
  logic signed [ROT_WIDTH-1:0] rot_r2c1;
  logic signed [ROT_WIDTH-1:0] rot_r2c2;
  logic signed [POS_WIDTH-1:0] pos_x;
  logic signed [POS_WIDTH-1:0] pos_y;
  logic signed [POS_WIDTH-1:0] pos_z;

  modport source (output valid, rot_r0c0, rot_r0c1, rot_r0c2, rot_r1c0, rot_r1c1,
                  rot_r1c2, rot_r2c0, rot_r2c1, rot_r2c2, pos_x, pos_y, pos_z,
                  input ready);
  modport sink (input valid, rot_r0c0, rot_r0c1, rot_r0c2, rot_r1c0, rot_r1c1,
                rot_r1c2, rot_r2c0, rot_r2c1, rot_r2c2, pos_x, pos_y, pos_z,
                output ready);
endinterface

### rtl/six_joint_forward_kinematics.sv
// Top level of the six-joint forward kinematics block.
// joints: valid/ready channel with six Q3.13 joint angles; an item is taken
//   when valid and ready are both high.
// pose: valid/ready channel with the 3x3 Q1.14 rotation and the Q3.16 xyz
//   tool position, one pose per item, in order.
// cfg_we/cfg_wdata: writes base_height (Q3.16) at the clock edge with cfg_we
//   high; write only while idle.
// Front end: iterative CORDIC, six lanes in parallel; it takes a new item in
//   the cycle its previous result enters the two-entry queue.
// Back end: two shared 32x32 multipliers compose the eight links, only the
//   offset for a pure offset link and offset plus rotation for the others;
//   it takes a new item only once its previous pose is in the output register.
// A stalled pose stays in its output register; the back end holds its
//   finished result and the queue fills, then joints.ready drops.
// Reset (rst, synchronous) empties the queue, idles both ends and sets
//   base_height to 2.0 m.
module six_joint_forward_kinematics import sfk_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_WIDTH-1:0] cfg_wdata,
  sfk_in_if.sink               joints,
  sfk_out_if.source            pose
);

  logic signed [CFG_WIDTH-1:0] base_height;
  trig_t push_data, head;
  logic push, pop;
  q_stat_t qs;

  always_ff @(posedge clk) begin
    if (rst) base_height <= BASE_HEIGHT_RST;
    else if (cfg_we) base_height <= $signed(cfg_wdata);
  end

  sfk_trig u_trig (
    .clk(clk), .rst(rst), .joints(joints),
    .push_data(push_data), .push(push), .qs(qs)
  );

  sfk_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data),
    .pop(pop), .head(head), .qs(qs)
  );

  sfk_chain u_chain (
    .clk(clk), .rst(rst), .head(head), .qs(qs), .pop(pop),
    .base_height(base_height), .pose(pose)
  );

endmodule

### rtl/sfk_trig.sv
// Front end: accepts joint angles and runs six CORDIC lanes for sine and cosine.
module sfk_trig import sfk_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  sfk_in_if.sink  joints,
  output trig_t   push_data,
  output logic    push,
  input  q_stat_t qs
);

  localparam int ITER_W = $clog2(CORDIC_STEPS);

  f_state_t state, state_next;
  logic [ITER_W-1:0] iter;
  logic signed [CORDIC_W-1:0] x [JOINTS];
  logic signed [CORDIC_W-1:0] y [JOINTS];
  logic signed [CORDIC_W-1:0] z [JOINTS];
  logic [1:0] quad [JOINTS];
  logic signed [ANGLE_WIDTH-1:0] ang [JOINTS];
  logic [31:0] phase [JOINTS];
  logic accept;

  assign ang[0] = joints.joint1_angle;
  assign ang[1] = joints.joint2_angle;
  assign ang[2] = joints.joint3_angle;
  assign ang[3] = joints.joint4_angle;
  assign ang[4] = joints.joint5_angle;
  assign ang[5] = joints.joint6_angle;

  assign push         = (state == F_PUSH) && !qs.full;
  assign joints.ready = (state == F_IDLE) || push;
  assign accept       = joints.valid && joints.ready;

  always_comb begin
    for (int j = 0; j < JOINTS; j++) begin
      phase[j] = 32'($signed(32'(ang[j])) * PHASE_MUL);
    end
  end

  // quadrant fold of the CORDIC result
  always_comb begin
    for (int j = 0; j < JOINTS; j++) begin
      case (quad[j])
        2'd0: begin
          push_data.cosv[j] = TRIG_W'(x[j]);
          push_data.sinv[j] = TRIG_W'(y[j]);
        end
        2'd1: begin
          push_data.cosv[j] = TRIG_W'(-y[j]);
          push_data.sinv[j] = TRIG_W'(x[j]);
        end
        2'd2: begin
          push_data.cosv[j] = TRIG_W'(-x[j]);
          push_data.sinv[j] = TRIG_W'(-y[j]);
        end
        default: begin
          push_data.cosv[j] = TRIG_W'(y[j]);
          push_data.sinv[j] = TRIG_W'(-x[j]);
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: if (accept) state_next = F_RUN;
      F_RUN: if (iter == ITER_W'(CORDIC_STEPS - 1)) state_next = F_PUSH;
      F_PUSH: begin
        if (push) state_next = accept ? F_RUN : F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      iter  <= '0;
    end else begin
      state <= state_next;
      if (accept) iter <= '0;
      else if (state == F_RUN) iter <= iter + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int j = 0; j < JOINTS; j++) begin
        x[j]    <= CORDIC_X0;
        y[j]    <= '0;
        z[j]    <= CORDIC_W'(phase[j][29:0]);
        quad[j] <= phase[j][31:30];
      end
    end else if (state == F_RUN) begin
      for (int j = 0; j < JOINTS; j++) begin
        if (!z[j][CORDIC_W-1]) begin
          x[j] <= x[j] - (y[j] >>> iter);
          y[j] <= y[j] + (x[j] >>> iter);
          z[j] <= z[j] - atan_val(5'(iter));
        end else begin
          x[j] <= x[j] + (y[j] >>> iter);
          y[j] <= y[j] - (x[j] >>> iter);
          z[j] <= z[j] + atan_val(5'(iter));
        end
      end
    end
  end

endmodule

### rtl/sfk_queue.sv
// Two-entry queue of sine/cosine sets between front and back.
module sfk_queue import sfk_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  trig_t   push_data,
  input  logic    pop,
  output trig_t   head,
  output q_stat_t qs
);

  trig_t mem [2];
  logic wr_ptr, rd_ptr;
  logic [1:0] count;

  assign head     = mem[rd_ptr];
  assign qs.full  = (count == 2'd2);
  assign qs.empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != 2'd2)) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != 2'd0)) else $error("queue underflow");

endmodule

### rtl/sfk_chain.sv
// Back end: composes the link transforms with two shared multipliers.
module sfk_chain import sfk_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  trig_t                       head,
  input  q_stat_t                     qs,
  output logic                        pop,
  input  logic signed [CFG_WIDTH-1:0] base_height,
  sfk_out_if.source                   pose
);

  localparam int RND_W  = PROD_W - 30;
  localparam int PSUM_W = (COORD_WIDTH > RND_W ? COORD_WIDTH : RND_W) + 1;
  localparam logic signed [PSUM_W-1:0] P_HI = PSUM_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 1);
  localparam logic signed [PSUM_W-1:0] P_LO = PSUM_W'(-(64'sd1 <<< (COORD_WIDTH - 1)));
  localparam logic signed [PROD_W-1:0] RND_HALF = 64'sd536870912;

  b_state_t state, state_next;
  trig_t trig;
  logic [2:0] link;
  logic [3:0] step;
  link_t li;
  logic signed [TRIG_W-1:0] r [3][3];
  logic signed [COORD_WIDTH-1:0] p [3];

  // issue stage
  logic issue, is_pos, selb, last_step, load_out;
  logic [3:0] rs;
  logic [1:0] row, col, cb;
  logic signed [TRIG_W-1:0] c, s, sg, r0, rk, a1, b1, a2, b2;

  // write stage
  logic wr_valid, wr_pos;
  logic [1:0] wr_row, wr_col;
  logic signed [PROD_W-1:0] prod_a, prod_b, sum;
  logic signed [RND_W-1:0] rnd;
  logic signed [PSUM_W-1:0] psum;

  assign li = link_info(link);
  assign rs = step - 4'd3;
  assign is_pos = (step < 4'd3);
  assign issue = (state == B_RUN) && (is_pos || ((li.axis != AX_NONE) && (step < 4'd9)));
  assign last_step = (li.axis == AX_NONE) ? (step == 4'd3) : (step == 4'd9);
  assign selb = rs[0];
  assign row = is_pos ? step[1:0] : rs[2:1];
  assign cb = (li.axis == AX_Z) ? 2'd1 : 2'd2;
  assign col = selb ? cb : 2'd0;

  always_comb begin
    c  = $signed(trig.cosv[li.joint]);
    s  = $signed(trig.sinv[li.joint]);
    sg = (li.axis == AX_Z) ? s : -s;
    r0 = r[row][0];
    rk = r[row][cb];
    if (is_pos) begin
      a1 = r[row][li.t_axis];
      b1 = TRIG_W'(li.t_val);
      a2 = '0;
      b2 = '0;
    end else begin
      // new col0 = r0*c + rk*sg, new col cb = -r0*sg + rk*c
      a1 = r0;
      b1 = selb ? -sg : c;
      a2 = rk;
      b2 = selb ? c : sg;
    end
  end

  assign sum  = prod_a + prod_b + RND_HALF;
  assign rnd  = sum[PROD_W-1:30];
  assign psum = PSUM_W'(p[wr_row]) + PSUM_W'(rnd);

  assign pop      = (state == B_IDLE) && !qs.empty;
  assign load_out = (state == B_DONE) && (!pose.valid || pose.ready);

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: if (pop) state_next = B_RUN;
      B_RUN: if (last_step && (link == 3'(LINKS - 1))) state_next = B_DONE;
      B_DONE: if (load_out) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      link     <= '0;
      step     <= '0;
      wr_valid <= 1'b0;
      pose.valid <= 1'b0;
    end else begin
      state    <= state_next;
      wr_valid <= issue;
      if (pop) begin
        link <= '0;
        step <= '0;
      end else if (state == B_RUN) begin
        if (last_step) begin
          step <= '0;
          link <= link + 1'b1;
        end else begin
          step <= step + 1'b1;
        end
      end
      if (load_out) pose.valid <= 1'b1;
      else if (pose.ready) pose.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    prod_a <= a1 * b1;
    prod_b <= a2 * b2;
    wr_pos <= is_pos;
    wr_row <= row;
    wr_col <= col;
    if (pop) begin
      trig <= head;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          r[i][j] <= (i == j) ? Q30_ONE : '0;
        end
      end
      p[0] <= '0;
      p[1] <= '0;
      p[2] <= COORD_WIDTH'(base_height);
    end else if (wr_valid) begin
      if (wr_pos) begin
        if (psum > P_HI) p[wr_row] <= COORD_WIDTH'(P_HI);
        else if (psum < P_LO) p[wr_row] <= COORD_WIDTH'(P_LO);
        else p[wr_row] <= COORD_WIDTH'(psum);
      end else begin
        r[wr_row][wr_col] <= TRIG_W'(rnd);
      end
    end
  end

  function automatic logic signed [ROT_WIDTH-1:0] rot_out(input logic signed [TRIG_W-1:0] v);
    logic signed [TRIG_W:0] t;
    logic signed [TRIG_W-16:0] q;
    t = (TRIG_W+1)'(v) + 33'sd32768;
    q = t[TRIG_W:16];
    if (q > (TRIG_W-15)'(ROT_LIMIT)) return ROT_WIDTH'(ROT_LIMIT);
    if (q < -(TRIG_W-15)'(ROT_LIMIT)) return ROT_WIDTH'(-ROT_LIMIT);
    return ROT_WIDTH'(q);
  endfunction

  function automatic logic signed [POS_WIDTH-1:0] pos_out(
    input logic signed [COORD_WIDTH-1:0] v);
    if (v > COORD_WIDTH'(POS_LIMIT)) return POS_WIDTH'(POS_LIMIT);
    if (v < -COORD_WIDTH'(POS_LIMIT)) return POS_WIDTH'(-POS_LIMIT);
    return POS_WIDTH'(v);
  endfunction

  always_ff @(posedge clk) begin
    if (load_out) begin
      pose.rot_r0c0 <= rot_out(r[0][0]);
      pose.rot_r0c1 <= rot_out(r[0][1]);
      pose.rot_r0c2 <= rot_out(r[0][2]);
      pose.rot_r1c0 <= rot_out(r[1][0]);
      pose.rot_r1c1 <= rot_out(r[1][1]);
      pose.rot_r1c2 <= rot_out(r[1][2]);
      pose.rot_r2c0 <= rot_out(r[2][0]);
      pose.rot_r2c1 <= rot_out(r[2][1]);
      pose.rot_r2c2 <= rot_out(r[2][2]);
      pose.pos_x    <= pos_out(p[0]);
      pose.pos_y    <= pos_out(p[1]);
      pose.pos_z    <= pos_out(p[2]);
    end
  end

  a_wr_in_run: assert property (@(posedge clk) disable iff (rst)
    wr_valid |-> $past(state == B_RUN)) else $error("write outside run");
  a_rot_range: assert property (@(posedge clk) disable iff (rst)
    pose.valid |-> (pose.rot_r1c1 <= 16'sd16384 && pose.rot_r1c1 >= -16'sd16384))
    else $error("rotation out of range");

endmodule

### dv/six_joint_forward_kinematics_tb.sv
// Testbench for the six-joint forward kinematics block: randomized angles, scoreboarded poses.
module six_joint_forward_kinematics_tb;
  import sfk_pkg::*;

  typedef struct {
    logic signed [ROT_WIDTH-1:0] rot [9];
    logic signed [POS_WIDTH-1:0] pos [3];
  } pose_t;

  class pose_scoreboard;
    longint height;
    pose_t  pending [$];
    int     mismatches;
    int     orphans;

    function new();
      height = 131072;
      mismatches = 0;
      orphans = 0;
    endfunction

    function longint fshift(longint v, int s);
      return v >>> s;
    endfunction

    function longint round30(longint v);
      return (v + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint atan_step(int i);
      longint arc_tab [20] = '{536870912, 316933406, 167458907, 85004756, 42667331,
        21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861, 10430, 5215, 2608, 1304};
      return arc_tab[i];
    endfunction

    function void trig(logic signed [ANGLE_WIDTH-1:0] ang, output longint c,
                       output longint s);
      logic [31:0] phase;
      longint x, y, z, dx, dy;
      phase = 32'(longint'(ang) * 83443);
      z = longint'(phase[29:0]);
      x = 652032874;
      y = 0;
      for (int i = 0; i < 20; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_step(i);
        end else begin
          x += dx; y -= dy; z += atan_step(i);
        end
      end
      case (phase[31:30])
        2'd0: begin c = x; s = y; end
        2'd1: begin c = -y; s = x; end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
    endfunction

    function void note_joints(logic signed [ANGLE_WIDTH-1:0] ang [6]);
      // per link: axis (0 none, 1 z, 2 y), joint, offset xyz in Q16
      int lk_axis [8] = '{1, 2, 2, 0, 2, 1, 2, 0};
      int lk_joint [8] = '{0, 1, 2, 0, 3, 4, 5, 0};
      longint lk_ofs [8][3] = '{'{0, 0, 8343}, '{0, 14480, 0}, '{40108, 0, 0},
        '{0, -11266, 0}, '{37506, 0, 0}, '{0, 7530, 0}, '{0, 0, -7583},
        '{0, 11246, 0}};
      longint r [3][3];
      longint m [3][3];
      longint n [3][3];
      longint p [3];
      longint c, s, acc, lo, hi;
      pose_t e;
      lo = -(64'sd1 <<< (COORD_WIDTH - 1));
      hi = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) r[i][j] = (i == j) ? (64'sd1 <<< 30) : 0;
      p = '{0, 0, height};
      for (int k = 0; k < 8; k++) begin
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++) m[i][j] = (i == j) ? (64'sd1 <<< 30) : 0;
        if (lk_axis[k] != 0) begin
          trig(ang[lk_joint[k]], c, s);
          if (lk_axis[k] == 1) begin
            m[0][0] = c; m[0][1] = -s; m[1][0] = s; m[1][1] = c;
          end else begin
            m[0][0] = c; m[0][2] = s; m[2][0] = -s; m[2][2] = c;
          end
        end
        for (int i = 0; i < 3; i++) begin
          acc = r[i][0] * lk_ofs[k][0] + r[i][1] * lk_ofs[k][1] + r[i][2] * lk_ofs[k][2];
          p[i] = clip(p[i] + round30(acc), lo, hi);
        end
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++)
            n[i][j] = round30(r[i][0] * m[0][j] + r[i][1] * m[1][j] + r[i][2] * m[2][j]);
        r = n;
      end
      for (int i = 0; i < 9; i++)
        e.rot[i] = ROT_WIDTH'(clip((r[i / 3][i % 3] + 32768) >>> 16, -ROT_LIMIT, ROT_LIMIT));
      for (int i = 0; i < 3; i++) e.pos[i] = POS_WIDTH'(clip(p[i], -POS_LIMIT, POS_LIMIT));
      pending.push_back(e);
    endfunction

    function void check_pose(pose_t got);
      pose_t e;
      bit bad;
      if (pending.size() == 0) begin
        orphans++;
        if (orphans + mismatches <= 10) $display("unexpected pose item");
        return;
      end
      e = pending.pop_front();
      bad = 0;
      for (int i = 0; i < 9; i++) if (got.rot[i] !== e.rot[i]) bad = 1;
      for (int i = 0; i < 3; i++) if (got.pos[i] !== e.pos[i]) bad = 1;
      if (bad) begin
        mismatches++;
        if (mismatches + orphans <= 10)
          $display("pose mismatch: exp rot %p pos %p, got rot %p pos %p",
                   e.rot, e.pos, got.rot, got.pos);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CFG_WIDTH-1:0] cfg_wdata = '0;
  bit calm = 0;
  longint cycles = 0;

  sfk_in_if joints ();
  sfk_out_if pose ();

  six_joint_forward_kinematics uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .joints(joints.sink), .pose(pose.source)
  );

  pose_scoreboard board = new();

  always #1 clk = ~clk;

  initial begin
    joints.valid = 0;
    joints.joint1_angle = 0; joints.joint2_angle = 0; joints.joint3_angle = 0;
    joints.joint4_angle = 0; joints.joint5_angle = 0; joints.joint6_angle = 0;
    pose.ready = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("six_joint_forward_kinematics test failed");
      $finish;
    end
  end

  // pose sink: random stalls except in calm stretches
  always @(posedge clk) begin
    if (!rst && pose.valid && pose.ready) begin
      pose_t got;
      got.rot = '{pose.rot_r0c0, pose.rot_r0c1, pose.rot_r0c2, pose.rot_r1c0,
                  pose.rot_r1c1, pose.rot_r1c2, pose.rot_r2c0, pose.rot_r2c1,
                  pose.rot_r2c2};
      got.pos = '{pose.pos_x, pose.pos_y, pose.pos_z};
      board.check_pose(got);
    end
    pose.ready <= rst ? 1'b0 : (calm || $urandom_range(99) >= 27);
  end

  task automatic write_height(logic [CFG_WIDTH-1:0] v);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    board.height = longint'(signed'(v));
  endtask

  // valid stays high into the next item; idle cycles and drain drop it
  task automatic send_joints(logic signed [ANGLE_WIDTH-1:0] a [6]);
    while (!calm && $urandom_range(99) < 27) begin
      joints.valid <= 0;
      @(posedge clk);
    end
    joints.valid <= 1;
    joints.joint1_angle <= a[0]; joints.joint2_angle <= a[1];
    joints.joint3_angle <= a[2]; joints.joint4_angle <= a[3];
    joints.joint5_angle <= a[4]; joints.joint6_angle <= a[5];
    do @(posedge clk); while (!joints.ready);
    board.note_joints(a);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    joints.valid <= 0;
    while (board.pending.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (120) @(posedge clk);
  endtask

  function automatic logic signed [ANGLE_WIDTH-1:0] rand_angle();
    case ($urandom_range(9))
      0: return ANGLE_WIDTH'($urandom);
      1: return $urandom_range(1) ? 16'sd25736 : -16'sd25736;
      2: return ANGLE_WIDTH'($urandom_range(8)) * 16'sd6434 - 16'sd25736;
      default: return ANGLE_WIDTH'(int'($urandom_range(51472)) - 25736);
    endcase
  endfunction

  initial begin
    logic signed [ANGLE_WIDTH-1:0] a [6];
    logic signed [ANGLE_WIDTH-1:0] picks [8] = '{16'sd0, 16'sd25736, -16'sd25736,
      16'sd12868, -16'sd12868, 16'sh7fff, 16'sh8000, 16'sd6434};
    logic [CFG_WIDTH-1:0] heights [5] = '{20'h0, 20'hB0000, 20'h50000, 20'h7FFFF, 20'h80000};
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: reset height, then extremes and quarter turns per joint
    for (int k = 0; k < 8; k++) begin
      foreach (a[j]) a[j] = picks[k];
      send_joints(a);
    end
    for (int j = 0; j < 6; j++) begin
      foreach (a[i]) a[i] = 0;
      a[j] = picks[1 + j % 4];
      send_joints(a);
    end
    drain();
    // height phases: range ends, zero, and values beyond the range
    for (int ph = 0; ph < 6; ph++) begin
      write_height(ph < 5 ? heights[ph] : CFG_WIDTH'($urandom));
      calm = (ph == 2);
      for (int n = 0; n < 105; n++) begin
        foreach (a[j]) a[j] = rand_angle();
        send_joints(a);
      end
      drain();
    end
    calm = 0;
    if (board.mismatches == 0 && board.orphans == 0 && board.pending.size() == 0)
      $display("six_joint_forward_kinematics test passed");
    else
      $display("six_joint_forward_kinematics test failed");
    $finish;
  end
endmodule

### sim.f
rtl/sfk_pkg.sv
rtl/sfk_if.sv
rtl/sfk_trig.sv
rtl/sfk_queue.sv
rtl/sfk_chain.sv
rtl/six_joint_forward_kinematics.sv
dv/six_joint_forward_kinematics_tb.sv
